[rtl/r50sm_pkg.sv]
package r50sm_pkg;

    typedef struct packed {
        logic        operation;
        logic [30:0] start_sector;
        logic [6:0]  sector_count;
    } t_req;

    typedef struct packed {
        logic        op_kind;
        logic [5:0]  device_index;
        logic [5:0]  parity_device;
        logic [24:0] device_sector;
        logic [27:0] byte_offset;
        logic [4:0]  byte_size;
        logic        device_down;
        logic        out_of_range;
        logic        last_chunk;
    } t_chunk;

    localparam int unsigned MaxResults = 33;
    localparam int unsigned MaxCount   = 64;

    localparam logic [1:0] RegDisks  = 2'd0;
    localparam logic [1:0] RegGroups = 2'd1;
    localparam logic [1:0] RegFailed = 2'd2;

endpackage

[rtl/raid50_sector_mapper_top.sv]
// Channel  Direction  Handshake                 Payload
// request  in         i_req_valid / o_req_ready r50sm_pkg::t_req
// chunk    out        o_chk_valid / i_chk_ready r50sm_pkg::t_chunk
// config   in         APB write/read            disks, groups, failed mask
// One request at a time; a request passes through S_GEOM before its first chunk starts.
// Each chunk runs four divisions through one shared restoring divider, each with launch
// and handoff, plus a decode state (S_CALC) and a state to load the chunk (S_OUT).
// Synchronous active-low reset clears control and restores default geometry.
// A chunk still held in the output register stalls the sequencer until its transfer.
module raid50_sector_mapper_top #(
    parameter int unsigned SECTORS_PER_BLOCK = 2,
    parameter int unsigned SECTOR_BYTES      = 8,
    parameter int unsigned DEVICE_BYTES      = 268435456,
    parameter int unsigned MAX_DEVICES       = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  r50sm_pkg::t_req   i_req,
    output logic              o_chk_valid,
    input  logic              i_chk_ready,
    output r50sm_pkg::t_chunk o_chk,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import r50sm_pkg::*;

    localparam int unsigned DW = 34;

    typedef enum logic [3:0] {
        S_IDLE, S_GEOM, S_D0, S_D1, S_D2, S_D3, S_CALC, S_OUT
    } t_state;

    t_state        r_state;
    logic [1:0]    r_sub;
    logic [3:0]    r_disks, r_groups;
    logic [63:0]   r_failed;
    logic [3:0]    r_d;
    logic [6:0]    r_ndev;
    logic [6:0]    r_spbd;
    logic          r_op;
    logic [31:0]   r_pos, r_end;
    logic [5:0]    r_nres;
    logic [DW-1:0] r_jumps, r_bnum, r_line, r_sq;
    logic [6:0]    r_rem, r_rem1;
    logic [2:0]    r_member;
    logic [4:0]    r_boffv, r_nsecv;
    logic [16:0]   r_sizev;
    logic [3:0]    r_par;
    logic [5:0]    r_devv;
    logic [3:0]    r_grpv;
    logic [47:0]   r_sfull, r_ofull;
    t_chunk        r_chk;
    logic          r_vld;

    // shared restoring divider
    logic [DW-1:0] r_dq, r_drem, r_dden;
    logic [5:0]    r_dcnt;
    logic          r_dbusy, r_ddone;
    logic [DW-1:0] w_trial;
    logic          w_start;
    logic [DW-1:0] w_num, w_den;

    logic          w_load;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[4:3])
            RegDisks:  prdata = {60'd0, r_disks};
            RegGroups: prdata = {60'd0, r_groups};
            RegFailed: prdata = r_failed;
            default:   prdata = '0;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_chk_valid = r_vld;
    assign o_chk = r_chk;

    assign w_trial = {r_drem[DW-2:0], r_dq[DW-1]};
    assign w_load  = (r_state == S_OUT) && (!r_vld || i_chk_ready);

    // effective geometry
    logic [3:0] w_dc, w_gc;
    logic [3:0] w_dmax;
    always_comb begin
        w_dmax = (MAX_DEVICES < 8) ? 4'(MAX_DEVICES) : 4'd8;
        if (w_dmax < 4'd2) w_dmax = 4'd2;
        w_dc = r_disks;
        if (w_dc < 4'd2) w_dc = 4'd2;
        if (w_dc > w_dmax) w_dc = w_dmax;
        w_gc = r_groups;
        if (w_gc < 4'd1) w_gc = 4'd1;
        if (w_gc > 4'd8) w_gc = 4'd8;
        for (int k = 0; k < 8; k++) begin
            if (w_gc > 4'd1 && 32'(w_dc) * 32'(w_gc) > 32'(MAX_DEVICES)) w_gc = w_gc - 4'd1;
        end
    end

    logic [31:0] w_cnt;
    assign w_cnt = (i_req.sector_count > 7'(MaxCount)) ? 32'(MaxCount)
                                                       : 32'(i_req.sector_count);

    // split the remainder of pos / (spb * (d - 1)) into block and sector within block
    logic [2:0] w_qs;
    logic [4:0] w_boff;
    always_comb begin
        w_qs = '0;
        for (int k = 1; k < 8; k++) begin
            if (r_rem >= 7'(k * SECTORS_PER_BLOCK)) w_qs = 3'(k);
        end
        w_boff = 5'(r_rem - 7'(32'(w_qs) * SECTORS_PER_BLOCK));
    end

    // parity skip and chunk length
    logic          w_hit;
    logic [5:0]    w_dev;
    logic [DW-1:0] w_sq;
    logic [31:0]   w_left;
    logic [4:0]    w_nsec;
    logic [16:0]   w_size;
    always_comb begin
        w_hit = ({1'b0, r_member} == r_par);
        w_dev = r_rem1[5:0];
        w_sq  = r_line;
        if (w_hit) begin
            if (r_rem1 + 7'd1 == r_ndev) begin
                w_dev = '0;
                w_sq  = r_line + DW'(1);
            end else begin
                w_dev = 6'(r_rem1 + 7'd1);
            end
        end
        w_left = r_end - r_pos;
        w_nsec = 5'(SECTORS_PER_BLOCK) - r_boffv;
        if (32'(w_nsec) > w_left) w_nsec = w_left[4:0];
        w_size = 17'(w_nsec) * 17'(SECTOR_BYTES);
    end

    logic w_last;
    assign w_last = (r_pos + 32'(r_nsecv) >= r_end) ||
                    (r_nres + 6'd1 >= 6'(MaxResults));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disks <= 4'd3; r_groups <= 4'd1; r_failed <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:3])
                RegDisks:  r_disks  <= pwdata[3:0];
                RegGroups: r_groups <= pwdata[3:0];
                RegFailed: r_failed <= pwdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0; r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (w_start) begin
                r_dbusy <= 1'b1; r_dq <= w_num; r_drem <= '0;
                r_dden <= w_den; r_dcnt <= 6'(DW);
            end else if (r_dbusy) begin
                if (w_trial >= r_dden) begin
                    r_drem <= w_trial - r_dden; r_dq <= {r_dq[DW-2:0], 1'b1};
                end else begin
                    r_drem <= w_trial; r_dq <= {r_dq[DW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 6'd1;
                if (r_dcnt == 6'd1) begin
                    r_dbusy <= 1'b0; r_ddone <= 1'b1;
                end
            end
        end
    end

    // divider launch selection
    always_comb begin
        w_start = 1'b0; w_num = '0; w_den = DW'(1);
        if (r_sub == 2'd0) begin
            case (r_state)
                S_D0: begin
                    w_start = 1'b1; w_num = DW'(r_pos); w_den = DW'(r_spbd);
                end
                S_D1: begin
                    w_start = 1'b1; w_num = r_bnum; w_den = DW'(r_ndev);
                end
                S_D2: begin
                    w_start = 1'b1; w_num = r_line; w_den = DW'(r_d);
                end
                S_D3: begin
                    w_start = 1'b1; w_num = DW'(r_devv); w_den = DW'(r_d);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_vld <= 1'b0; r_sub <= '0;
        end else begin
            if (w_load) r_vld <= 1'b1;
            else if (i_chk_ready) r_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid && w_cnt != 32'd0) begin
                        r_op <= i_req.operation;
                        r_pos <= 32'(i_req.start_sector);
                        r_end <= 32'(i_req.start_sector) + w_cnt;
                        r_nres <= '0;
                        r_state <= S_GEOM;
                    end
                end
                S_GEOM: begin
                    r_d <= w_dc;
                    r_ndev <= 7'(w_dc) * 7'(w_gc);
                    r_spbd <= 7'(w_dc - 4'd1) * 7'(SECTORS_PER_BLOCK);
                    r_sub <= '0; r_state <= S_D0;
                end
                S_D0: begin
                    // jumps = pos / (spb * (d - 1)); block = jumps * d + block in group
                    if (r_sub == 2'd0) r_sub <= 2'd1;
                    else if (r_sub == 2'd1) begin
                        if (r_ddone) begin
                            r_jumps <= r_dq; r_rem <= r_drem[6:0]; r_sub <= 2'd2;
                        end
                    end else begin
                        r_bnum <= r_jumps * DW'(r_d) + DW'(w_qs);
                        r_member <= w_qs;
                        r_boffv <= w_boff;
                        r_sub <= '0; r_state <= S_D1;
                    end
                end
                S_D1: begin
                    if (r_sub == 2'd0) r_sub <= 2'd1;
                    else if (r_ddone) begin
                        r_line <= r_dq; r_rem1 <= r_drem[6:0];
                        r_sub <= '0; r_state <= S_D2;
                    end
                end
                S_D2: begin
                    if (r_sub == 2'd0) r_sub <= 2'd1;
                    else if (r_ddone) begin
                        r_par <= r_d - 4'd1 - r_drem[3:0];
                        r_sub <= '0; r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_devv <= w_dev; r_sq <= w_sq;
                    r_nsecv <= w_nsec; r_sizev <= w_size;
                    r_sub <= '0; r_state <= S_D3;
                end
                S_D3: begin
                    // device sector and byte offset are built while the divider runs
                    if (r_sub == 2'd0) begin
                        r_sfull <= 48'(r_sq) * 48'(SECTORS_PER_BLOCK) + 48'(r_boffv);
                        r_sub <= 2'd1;
                    end else if (r_sub == 2'd1) begin
                        r_ofull <= r_sfull * 48'(SECTOR_BYTES);
                        r_sub <= 2'd2;
                    end else if (r_ddone) begin
                        r_grpv <= r_dq[3:0];
                        r_sub <= '0; r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_chk.op_kind <= r_op;
                        r_chk.device_index <= r_devv;
                        r_chk.parity_device <= 6'(r_par) + 6'(r_grpv) * 6'(r_d);
                        r_chk.device_sector <= r_sfull[24:0];
                        r_chk.byte_offset <= r_ofull[27:0];
                        r_chk.byte_size <= r_sizev[4:0];
                        r_chk.device_down <= r_failed[r_devv];
                        r_chk.out_of_range <= (r_ofull + 48'(r_sizev)) > 48'(DEVICE_BYTES);
                        r_chk.last_chunk <= w_last;
                        r_pos <= r_pos + 32'(r_nsecv);
                        r_nres <= r_nres + 6'd1;
                        r_state <= w_last ? S_IDLE : S_D0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[sim/raid50_sector_mapper_top_tb.sv]
module raid50_sector_mapper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import r50sm_pkg::*;

    localparam int unsigned SPB        = 2;
    localparam int unsigned SECT_BYTES = 8;
    localparam longint unsigned DEV_BYTES = 268435456;
    localparam logic [1:0]  RegSpare   = 2'd3;
    localparam logic        OpRead     = 1'b0;
    localparam logic        OpWrite    = 1'b1;
    localparam int          DRAIN_CYC  = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        o_req_ready;
    t_req        req_data = '0;
    logic        o_chk_valid;
    logic        chk_ready = 1'b0;
    t_chunk      o_chk;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    raid50_sector_mapper_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_valid), .o_req_ready(o_req_ready), .i_req(req_data),
        .o_chk_valid(o_chk_valid), .i_chk_ready(chk_ready), .o_chk(o_chk),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the mapper's registers
    logic [3:0]  geo_disks = 4'd3;
    logic [3:0]  geo_groups = 4'd1;
    logic [63:0] failed_mask = '0;

    t_req   pending_reqs[$];
    t_chunk expected_chunks[$];
    int     n_errors = 0;
    int     n_reqs = 0;
    int     n_chunks = 0;
    int     n_oor = 0;
    int     n_down = 0;
    int     gap_left = 0;
    int     burst_left = 0;
    int     stall_period = 1;
    int     stall_len = 0;
    int     stall_cnt = 0;

    function automatic void map_request(t_req r);
        longint unsigned cnt, d, g, ndev, fin, s, lblock, jumps, rsec, blk;
        longint unsigned row, par, member, dev, grp, boff, sstart, ofs, nsec, sz;
        int n;
        t_chunk c;
        cnt = r.sector_count;
        if (cnt > MaxCount) cnt = MaxCount;
        if (cnt == 0) return;
        d = geo_disks;
        if (d < 2) d = 2;
        if (d > 8) d = 8;
        g = geo_groups;
        if (g < 1) g = 1;
        if (g > 8) g = 8;
        while (g > 1 && d * g > 64) g--;
        ndev = d * g;
        fin = longint'(r.start_sector) + cnt;
        n = 0;
        s = r.start_sector;
        while (s < fin && n < MaxResults) begin
            lblock = s / SPB;
            jumps = lblock / (d - 1);
            rsec = s + jumps * SPB;
            blk = lblock + jumps;
            row = blk / ndev;
            par = d - 1 - (row % d);
            member = blk % d;
            // data block landed on the rotating parity slot: skip one block
            if (member == par) begin
                blk++;
                rsec += SPB;
            end
            dev = blk % ndev;
            grp = dev / d;
            boff = rsec % SPB;
            sstart = (rsec / (ndev * SPB)) * SPB + boff;
            ofs = sstart * SECT_BYTES;
            nsec = SPB - boff;
            if (nsec > fin - s) nsec = fin - s;
            sz = nsec * SECT_BYTES;
            c.op_kind       = r.operation;
            c.device_index  = dev[5:0];
            c.parity_device = 6'(par + grp * d);
            c.device_sector = sstart[24:0];
            c.byte_offset   = ofs[27:0];
            c.byte_size     = sz[4:0];
            c.device_down   = (dev < 64) ? failed_mask[dev[5:0]] : 1'b0;
            c.out_of_range  = (ofs + sz > DEV_BYTES);
            s += nsec;
            n++;
            c.last_chunk    = (s >= fin || n >= MaxResults);
            expected_chunks.push_back(c);
        end
    endfunction

    // request driver: bursts with random gaps
    always @(posedge i_clk) begin
        logic nv;
        t_req np;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            nv = req_valid;
            np = req_data;
            if (req_valid && o_req_ready) begin
                map_request(req_data);
                n_reqs++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    np = pending_reqs.pop_front();
                    nv = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 10);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
            end
            req_valid <= nv;
            req_data <= np;
        end
    end

    // chunk monitor and stall pattern
    always @(posedge i_clk) begin
        t_chunk e;
        if (!i_rst_n) begin
            chk_ready <= 1'b0;
        end else begin
            if (o_chk_valid && chk_ready) begin
                n_chunks++;
                if (expected_chunks.size() == 0) begin
                    $error("chunk transfer with nothing expected: %p", o_chk);
                    n_errors++;
                end else begin
                    e = expected_chunks.pop_front();
                    if (o_chk.out_of_range) n_oor++;
                    if (o_chk.device_down) n_down++;
                    if (o_chk.op_kind !== e.op_kind) begin
                        $error("op_kind exp %0d got %0d", e.op_kind, o_chk.op_kind);
                        n_errors++;
                    end
                    if (o_chk.device_index !== e.device_index) begin
                        $error("device_index exp %0d got %0d", e.device_index,
                               o_chk.device_index);
                        n_errors++;
                    end
                    if (o_chk.parity_device !== e.parity_device) begin
                        $error("parity_device exp %0d got %0d", e.parity_device,
                               o_chk.parity_device);
                        n_errors++;
                    end
                    if (o_chk.device_sector !== e.device_sector) begin
                        $error("device_sector exp %0d got %0d", e.device_sector,
                               o_chk.device_sector);
                        n_errors++;
                    end
                    if (o_chk.byte_offset !== e.byte_offset) begin
                        $error("byte_offset exp %0d got %0d", e.byte_offset,
                               o_chk.byte_offset);
                        n_errors++;
                    end
                    if (o_chk.byte_size !== e.byte_size) begin
                        $error("byte_size exp %0d got %0d", e.byte_size, o_chk.byte_size);
                        n_errors++;
                    end
                    if (o_chk.device_down !== e.device_down) begin
                        $error("device_down exp %0d got %0d", e.device_down,
                               o_chk.device_down);
                        n_errors++;
                    end
                    if (o_chk.out_of_range !== e.out_of_range) begin
                        $error("out_of_range exp %0d got %0d", e.out_of_range,
                               o_chk.out_of_range);
                        n_errors++;
                    end
                    if (o_chk.last_chunk !== e.last_chunk) begin
                        $error("last_chunk exp %0d got %0d", e.last_chunk,
                               o_chk.last_chunk);
                        n_errors++;
                    end
                end
            end
            stall_cnt = (stall_cnt + 1) % stall_period;
            if (stall_cnt == 0 && $urandom_range(0, 15) == 0) begin
                // new pattern; period 1 with no stall means always ready
                stall_period = $urandom_range(1, 12);
                stall_len = $urandom_range(0, stall_period - 1);
            end
            chk_ready <= (stall_cnt >= stall_len);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            RegDisks:  geo_disks = val[3:0];
            RegGroups: geo_groups = val[3:0];
            RegFailed: failed_mask = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        // sample between edges so the driver's updates have settled
        while (pending_reqs.size() > 0 || req_valid || expected_chunks.size() > 0)
            @(negedge i_clk);
        // zero-count requests produce nothing; let the block settle
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic t_req rand_req();
        t_req r;
        int sel;
        r.operation = $urandom_range(0, 1) ? OpWrite : OpRead;
        sel = $urandom_range(0, 9);
        if (sel < 5) r.start_sector = 31'($urandom);
        else if (sel < 8) r.start_sector = 31'($urandom_range(0, 200));
        else r.start_sector = 31'h7fff_ffff - 31'($urandom_range(0, 100));
        sel = $urandom_range(0, 99);
        if (sel < 75) r.sector_count = 7'($urandom_range(1, 8));
        else if (sel < 93) r.sector_count = 7'($urandom_range(9, 64));
        else if (sel < 97) r.sector_count = 7'($urandom_range(65, 127));
        else r.sector_count = 7'd0;
        return r;
    endfunction

    function automatic t_req mk(logic op, logic [30:0] st, logic [6:0] cnt);
        t_req r;
        r.operation = op;
        r.start_sector = st;
        r.sector_count = cnt;
        return r;
    endfunction

    initial begin
        logic [3:0] disk_cfg[8] = '{4'd3, 4'd2, 4'd8, 4'd0, 4'd15, 4'd8, 4'd2, 4'd5};
        logic [3:0] grp_cfg[8]  = '{4'd1, 4'd1, 4'd8, 4'd0, 4'd15, 4'd1, 4'd8, 4'd3};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed requests at reset geometry
        pending_reqs.push_back(mk(OpRead, 31'd0, 7'd1));
        pending_reqs.push_back(mk(OpWrite, 31'd0, 7'd64));
        pending_reqs.push_back(mk(OpRead, 31'd1, 7'd64));
        pending_reqs.push_back(mk(OpWrite, 31'd1, 7'd2));
        pending_reqs.push_back(mk(OpRead, 31'd5, 7'd0));
        pending_reqs.push_back(mk(OpWrite, 31'd3, 7'd127));
        pending_reqs.push_back(mk(OpRead, 31'd7, 7'd65));
        pending_reqs.push_back(mk(OpWrite, 31'h7fff_ffff, 7'd1));
        pending_reqs.push_back(mk(OpRead, 31'h7fff_ffc1, 7'd64));
        pending_reqs.push_back(mk(OpWrite, 31'h4000_0000, 7'd9));
        pending_reqs.push_back(mk(OpRead, 31'h2aaa_aaaa, 7'd33));
        pending_reqs.push_back(mk(OpWrite, 31'h5555_5555, 7'h55));
        pending_reqs.push_back(mk(OpRead, 31'd12, 7'd12));
        pending_reqs.push_back(mk(OpWrite, 31'd100, 7'd3));
        wait_drained();
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(RegDisks, {60'h0, disk_cfg[ph]});
            reg_write(RegGroups, {60'h0, grp_cfg[ph]});
            if (ph == 1) reg_write(RegFailed, '1);
            else if (ph == 3) reg_write(RegFailed, '0);
            else reg_write(RegFailed, {$urandom, $urandom});
            if (ph == 4) reg_write(RegSpare, {$urandom, $urandom});
            for (int k = 0; k < 46; k++) pending_reqs.push_back(rand_req());
            wait_drained();
        end
        $display("requests %0d, chunks %0d (out of range %0d, failed device %0d)",
                 n_reqs, n_chunks, n_oor, n_down);
        $display("geometries: reset, clamped low/high, 2..8 disks, 1..8 groups");
        if (n_errors == 0 && expected_chunks.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #80ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/r50sm_pkg.sv
rtl/raid50_sector_mapper_top.sv
sim/raid50_sector_mapper_top_tb.sv
